FILE: hw/rtl/bcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button click classifier package
// Shared widths, event codes, register indexes and a counter helper.
// ----------------------------------------------------------------------------
package bcc_pkg;

	// Width of the hold and release tick counters.
	localparam int COUNT_W = 16;
	// Width of the threshold registers.
	localparam int THR_W = 16;
	// Width used when a counter is compared against a threshold.
	localparam int CMP_W = (COUNT_W > THR_W) ? COUNT_W : THR_W;

	// Configuration port widths.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = THR_W;

	typedef logic [COUNT_W-1:0] cnt_t;
	typedef logic [THR_W-1:0]   thr_t;
	typedef logic [CMP_W-1:0]   cmp_t;

	// Event codes carried by each result word.
	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_SINGLE = 2'd1,
		EV_DOUBLE = 2'd2,
		EV_LONG   = 2'd3
	} click_ev_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ACTIVE_LEVEL = 2'd0,
		REG_LONG_TICKS   = 2'd1,
		REG_GAP_MIN      = 2'd2,
		REG_GAP_MAX      = 2'd3
	} cfg_idx_t;

	// Reset values of the threshold registers.
	localparam thr_t LONG_RST    = THR_W'(500);
	localparam thr_t GAP_MIN_RST = THR_W'(50);
	localparam thr_t GAP_MAX_RST = THR_W'(300);

	// Increment that sticks at the counter's all-ones value.
	function automatic cnt_t sat_inc(input cnt_t v);
		cnt_t r;
		if (v == {COUNT_W{1'b1}}) begin
			r = v;
		end else begin
			r = v + cnt_t'(1);
		end
		return r;
	endfunction

endpackage

FILE: hw/rtl/bcc_pin_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pin sample channel
// Valid/ready channel carrying one sampled pin level per word.
// ----------------------------------------------------------------------------
interface bcc_pin_if;
	logic valid;
	logic ready;
	logic pin_level;

	modport source (output valid, output pin_level, input ready);
	modport sink   (input valid, input pin_level, output ready);
endinterface

FILE: hw/rtl/bcc_event_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Click event channel
// Valid/ready channel carrying one click event code per word.
// ----------------------------------------------------------------------------
interface bcc_event_if;
	logic       valid;
	logic       ready;
	logic [1:0] click_event;

	modport source (output valid, output click_event, input ready);
	modport sink   (input valid, input click_event, output ready);
endinterface

FILE: hw/rtl/button_click_classifier_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button click classifier core
// Classifies scan ticks of one button pin into single click, double click
// and long press events, one event word per tick.
//
//   channel  | dir | payload
//   ---------+-----+---------------------------
//   sample   | in  | pin_level   (1 bit)
//   click    | out | click_event (2 bits)
//   cfg_*    | in  | write enable, index, data
//
// One word per cycle sustained while the output is not stalled; a tick goes
// through the input register and its event is then registered in the output
// register. The counter update is a single pass between those registers.
// Reset clears the counters and flags and loads the default thresholds.
// A stalled output register holds its word; the input register still takes
// a word while the output register is empty or being drained.
// ----------------------------------------------------------------------------
module button_click_classifier_core (
	input  logic                           clk,
	input  logic                           arst_n,
	bcc_pin_if.sink                        sample,
	bcc_event_if.source                    click,
	input  logic                           cfg_we,
	input  logic [bcc_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [bcc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	// Configuration registers.
	logic               active_level_q;
	bcc_pkg::thr_t      long_ticks_q;
	bcc_pkg::thr_t      gap_min_q;
	bcc_pkg::thr_t      gap_max_q;

	// Detector state.
	logic               press_seen_q;
	bcc_pkg::cnt_t      hold_q;
	bcc_pkg::cnt_t      release_q;
	logic               detected_q;

	// Input stage and output register.
	logic               valid_s1;
	logic               pin_s1;
	logic               out_valid_q;
	bcc_pkg::click_ev_t out_ev_q;

	// Next-state values from the single pass.
	logic               pressed;
	logic               ps_d;
	bcc_pkg::cnt_t      hold_d;
	bcc_pkg::cnt_t      rel_d;
	logic               det_d;
	bcc_pkg::click_ev_t ev_d;
	logic               adv;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_level_q <= 1'b0;
			long_ticks_q   <= bcc_pkg::LONG_RST;
			gap_min_q      <= bcc_pkg::GAP_MIN_RST;
			gap_max_q      <= bcc_pkg::GAP_MAX_RST;
		end else if (cfg_we) begin
			case (bcc_pkg::cfg_idx_t'(cfg_idx))
				bcc_pkg::REG_ACTIVE_LEVEL: active_level_q <= cfg_wdata[0];
				bcc_pkg::REG_LONG_TICKS:   long_ticks_q   <= cfg_wdata;
				bcc_pkg::REG_GAP_MIN:      gap_min_q      <= cfg_wdata;
				bcc_pkg::REG_GAP_MAX:      gap_max_q      <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Handshake: the input stage moves on when the output register is free.
	assign adv          = valid_s1 && (!out_valid_q || click.ready);
	assign sample.ready = !valid_s1 || adv;
	assign click.valid  = out_valid_q;
	assign click.click_event = out_ev_q;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			pin_s1 <= sample.pin_level;
		end
	end

	// Classification pass for the tick in the input register.
	always_comb begin
		pressed = (pin_s1 == active_level_q);
		ps_d    = press_seen_q;
		hold_d  = hold_q;
		rel_d   = release_q;
		det_d   = detected_q;
		ev_d    = bcc_pkg::EV_NONE;

		// Clear after a report; a released tick re-arms.
		if (detected_q) begin
			ps_d   = 1'b0;
			hold_d = '0;
			rel_d  = '0;
			if (!pressed) begin
				det_d = 1'b0;
			end
		end

		// Count hold time while armed.
		if (pressed && !det_d) begin
			ps_d   = 1'b1;
			hold_d = bcc_pkg::sat_inc(hold_d);
		end

		if (bcc_pkg::cmp_t'(hold_d) > bcc_pkg::cmp_t'(long_ticks_q)) begin
			det_d = 1'b1;
			ev_d  = bcc_pkg::EV_LONG;
		end else begin
			// Count released ticks after a press.
			if (ps_d && !pressed) begin
				rel_d = bcc_pkg::sat_inc(rel_d);
			end
			if (ps_d && (bcc_pkg::cmp_t'(rel_d) > bcc_pkg::cmp_t'(gap_min_q))
					&& (bcc_pkg::cmp_t'(rel_d) < bcc_pkg::cmp_t'(gap_max_q))) begin
				if (pressed) begin
					det_d = 1'b1;
					ev_d  = bcc_pkg::EV_DOUBLE;
				end
			end else if (ps_d && (bcc_pkg::cmp_t'(rel_d) > bcc_pkg::cmp_t'(gap_max_q))) begin
				det_d = 1'b1;
				ev_d  = bcc_pkg::EV_SINGLE;
			end
		end
	end

	// State update, one tick per advance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_seen_q <= 1'b0;
			hold_q       <= '0;
			release_q    <= '0;
			detected_q   <= 1'b0;
		end else if (adv) begin
			press_seen_q <= ps_d;
			hold_q       <= hold_d;
			release_q    <= rel_d;
			detected_q   <= det_d;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (click.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_ev_q <= ev_d;
		end
	end

	// A reported event leaves the detector disarmed.
	assert property (@(posedge clk) disable iff (!arst_n)
		(adv && ev_d != bcc_pkg::EV_NONE) |=> detected_q)
		else $error("event reported without setting the detected flag");

	// Hold time only accumulates after a press has been seen.
	assert property (@(posedge clk) disable iff (!arst_n)
		(hold_q != '0) |-> press_seen_q)
		else $error("hold count set without a press");

	// Release time only accumulates after a press has been seen.
	assert property (@(posedge clk) disable iff (!arst_n)
		(release_q != '0) |-> press_seen_q)
		else $error("release count set without a press");

	// An empty output register never blocks the input.
	assert property (@(posedge clk) disable iff (!arst_n)
		!click.valid |-> sample.ready)
		else $error("input stalled while output register is empty");

endmodule

FILE: dv/bcc_click_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Click event checker
// Watches the pin sample, click event and configuration ports of the button
// click classifier. It keeps its own copy of the thresholds and detector
// state, and predicts one event per accepted pin word. Each event word that
// leaves the core is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module bcc_click_checker
	import bcc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	bcc_pin_if                    sample,
	bcc_event_if                  click,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output int                    fail_count,
	output int                    pending
);

	// Shadow copy of the configuration registers.
	logic act_level;
	thr_t long_thr;
	thr_t gap_lo;
	thr_t gap_hi;

	// Shadow copy of the detector state.
	logic press_armed;
	cnt_t hold_ticks;
	cnt_t gap_ticks;
	logic reported;

	// Events predicted for accepted pin words, oldest first.
	click_ev_t expected_events[$];

	// Advance the detector by one scan tick and return the event it reports.
	function automatic click_ev_t classify_tick(input logic pin);
		logic      pressed;
		click_ev_t ev;
		pressed = (pin == act_level);
		ev = EV_NONE;

		// A report clears everything; the button must be released to re-arm.
		if (reported) begin
			press_armed = 1'b0;
			hold_ticks = '0;
			gap_ticks = '0;
			if (!pressed) begin
				reported = 1'b0;
			end
		end

		// Count hold time while armed, sticking at the counter maximum.
		if (pressed && !reported) begin
			press_armed = 1'b1;
			if (hold_ticks != '1) begin
				hold_ticks = hold_ticks + cnt_t'(1);
			end
		end

		if (hold_ticks > long_thr) begin
			reported = 1'b1;
			ev = EV_LONG;
		end else begin
			// Count the release gap after a press.
			if (press_armed && !pressed && gap_ticks != '1) begin
				gap_ticks = gap_ticks + cnt_t'(1);
			end
			// A press inside the gap window is a double click; a gap past the
			// window is a single click. A gap equal to the upper bound gives
			// neither.
			if (press_armed && gap_ticks > gap_lo && gap_ticks < gap_hi) begin
				if (pressed) begin
					reported = 1'b1;
					ev = EV_DOUBLE;
				end
			end else if (press_armed && gap_ticks > gap_hi) begin
				reported = 1'b1;
				ev = EV_SINGLE;
			end
		end
		return ev;
	endfunction

	// Track register writes, predict on accepted pin words, check event words.
	always @(posedge clk or negedge arst_n) begin : watch
		click_ev_t want;
		logic [1:0] got;
		if (!arst_n) begin
			act_level = 1'b0;
			long_thr = LONG_RST;
			gap_lo = GAP_MIN_RST;
			gap_hi = GAP_MAX_RST;
			press_armed = 1'b0;
			hold_ticks = '0;
			gap_ticks = '0;
			reported = 1'b0;
			expected_events.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_idx))
					REG_ACTIVE_LEVEL: act_level = cfg_wdata[0];
					REG_LONG_TICKS:   long_thr = cfg_wdata;
					REG_GAP_MIN:      gap_lo = cfg_wdata;
					REG_GAP_MAX:      gap_hi = cfg_wdata;
					default: ;
				endcase
			end

			if (sample.valid && sample.ready) begin
				expected_events.push_back(classify_tick(sample.pin_level));
			end

			if (click.valid && click.ready) begin
				got = click.click_event;
				if (expected_events.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("%0t: event word %0d arrived with nothing expected",
							$time, got);
					end
				end else begin
					want = expected_events.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("%0t: click_event expected %0d (%s), got %0d",
								$time, want, want.name(), got);
						end
					end
				end
			end
			pending = expected_events.size();
		end
	end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button click classifier testbench
// Drives scan ticks into the classifier core as press and release gestures
// with random lengths around the configured thresholds, mixed with random
// pin noise, over a series of register settings. A side checker predicts
// and compares every event word. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module tb;
	import bcc_pkg::*;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	int                    fail_count;
	int                    pending;

	bcc_pin_if   sample_ch();
	bcc_event_if click_ch();

	// Stimulus bookkeeping and the settings currently loaded.
	logic idle_on;
	int   sent;
	logic cur_level;
	thr_t cur_long;
	thr_t cur_gap_hi;

	button_click_classifier_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample_ch),
		.click     (click_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	bcc_click_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample     (sample_ch),
		.click      (click_ch),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// 50 MHz clock.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Send one pin word, possibly after an idle burst, and wait until taken.
	task automatic send_tick(input logic pin);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 19);
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.pin_level <= pin;
		do @(posedge clk); while (!sample_ch.ready);
		sent++;
	endtask

	task automatic send_run(input logic pressed, input int n);
		repeat (n) send_tick(pressed ? cur_level : ~cur_level);
	endtask

	// Stop sending and wait until every predicted event has come out.
	task automatic drain();
		sample_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	// Load all four registers, one per cycle.
	task automatic set_config(input logic [CFG_DATA_W-1:0] lvl_word, input thr_t lng,
			input thr_t glo, input thr_t ghi);
		cfg_we <= 1'b1;
		cfg_idx <= REG_ACTIVE_LEVEL;
		cfg_wdata <= lvl_word;
		@(posedge clk);
		cfg_idx <= REG_LONG_TICKS;
		cfg_wdata <= lng;
		@(posedge clk);
		cfg_idx <= REG_GAP_MIN;
		cfg_wdata <= glo;
		@(posedge clk);
		cfg_idx <= REG_GAP_MAX;
		cfg_wdata <= ghi;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_level = lvl_word[0];
		cur_long = lng;
		cur_gap_hi = ghi;
	endtask

	// Mostly small thresholds, with the extremes and full-range values mixed in.
	function automatic thr_t pick_thr(input int small_max);
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return thr_t'($urandom);
			default: return thr_t'($urandom_range(0, small_max));
		endcase
	endfunction

	// The event side accepts in stretches, stalling in bursts while idling is on.
	initial begin
		click_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (idle_on && $urandom_range(0, 2) == 0) begin
				click_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			click_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 30)) @(posedge clk);
		end
	end

	// Main stimulus sequence.
	initial begin
		int ph;
		int target;
		int hold_cap;
		int gap_cap;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_idx <= REG_ACTIVE_LEVEL;
		cfg_wdata <= '0;
		sample_ch.valid <= 1'b0;
		sample_ch.pin_level <= 1'b0;
		idle_on = 1'b1;
		sent = 0;
		cur_level = 1'b0;
		cur_long = LONG_RST;
		cur_gap_hi = GAP_MAX_RST;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A few ticks under the reset settings.
		send_run(1'b1, 3);
		send_run(1'b0, 2);
		drain();

		// Long press, double click, single click after a gap one past the
		// upper bound, and a second press too early for a double click.
		set_config(16'h0001, 16'd4, 16'd1, 16'd4);
		send_run(1'b1, 6);
		send_run(1'b0, 1);
		send_run(1'b1, 1);
		send_run(1'b0, 2);
		send_run(1'b1, 1);
		send_run(1'b0, 1);
		send_run(1'b1, 1);
		send_run(1'b0, 5);
		send_run(1'b0, 1);
		send_run(1'b1, 1);
		send_run(1'b0, 1);
		send_run(1'b1, 2);
		drain();

		// All thresholds at zero: every press is a long press at once and no
		// double click is possible. Upper data bits are ignored.
		set_config(16'hFFFE, 16'd0, 16'd0, 16'd0);
		send_run(1'b1, 2);
		send_run(1'b0, 1);
		send_run(1'b1, 1);
		send_run(1'b0, 2);
		drain();

		// With every threshold at the counter maximum a long hold, a long gap
		// and a new press report nothing.
		idle_on = 1'b0;
		set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_run(1'b1, 20);
		send_run(1'b0, 20);
		send_run(1'b1, 3);
		drain();

		// Random gestures over many settings; the last two phases run without
		// idling on either side.
		for (ph = 0; ph < 12; ph++) begin
			idle_on = (ph < 10);
			set_config(CFG_DATA_W'($urandom), pick_thr(24), pick_thr(8), pick_thr(16));
			hold_cap = (cur_long < 24) ? int'(cur_long) + 2 : 26;
			gap_cap = (cur_gap_hi < 24) ? int'(cur_gap_hi) + 3 : 27;
			target = sent + 136;
			while (sent < target) begin
				if ($urandom_range(0, 4) == 0) begin
					repeat ($urandom_range(1, 6)) send_tick(1'($urandom_range(0, 1)));
				end else begin
					send_run(1'b1, $urandom_range(1, hold_cap));
					send_run(1'b0, $urandom_range(1, gap_cap));
				end
			end
			drain();
		end

		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("button_click_classifier_core test passed");
		end else begin
			$display("button_click_classifier_core test failed");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#20_000_000;
		$display("button_click_classifier_core test failed");
		$finish;
	end

endmodule
